[hw/rtl/cpu_task_scheduler_rr_hpf_srtn_unit_macros.svh]
// Assertion macros for the task scheduler.
`ifndef CPU_TASK_SCHEDULER_RR_HPF_SRTN_UNIT_MACROS_SVH
`define CPU_TASK_SCHEDULER_RR_HPF_SRTN_UNIT_MACROS_SVH
`ifndef SYNTH
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CTS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/cts_pkg.sv]
// Types and constants shared by the task scheduler modules.
package cts_pkg;
	localparam int IdW = 8;
	localparam int RemW = 16;
	localparam int PriW = 8;
	localparam int OrdW = 16;
	localparam int QntW = 8;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_START = 3'd1;
	localparam logic [2:0] EV_RESUME = 3'd2;
	localparam logic [2:0] EV_FINISH = 3'd3;
	localparam logic [2:0] EV_PREEMPT = 3'd4;
	localparam logic [2:0] EV_DROP = 3'd5;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] MODE_RR = 2'd0;
	localparam logic [1:0] MODE_HPF = 2'd1;
	localparam logic [1:0] MODE_SRTN = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_QUANTUM = 1'b1;

	typedef struct packed {
		logic operation;
		logic [IdW-1:0] task_id;
		logic [RemW-1:0] run_time;
		logic [PriW-1:0] task_priority;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [IdW-1:0] subject_id;
		logic cpu_busy;
		logic [IdW-1:0] current_id;
		logic [RemW-1:0] current_remaining;
		logic last_result;
	} out_item_t;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic [RemW-1:0] rem;
		logic [PriW-1:0] pri;
		logic started;
		logic [OrdW-1:0] order;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DISPATCH,
		ST_REINSERT,
		ST_EMIT1,
		ST_EMIT2
	} state_t;
endpackage

[hw/rtl/cpu_task_scheduler_rr_hpf_srtn_unit.sv]
// The first result of a request is followed by the second one, if there is one.
// One slot per cycle runs through a single shared compare unit during the table scan.
// One item is handled at a time; ready returns after all results are taken.
// Results sit in an output register; the next item is accepted only after the last one.
// Reset (arst_n low, asynchronous) empties the table and idles the CPU; no clearing pass.
module cpu_task_scheduler_rr_hpf_srtn_unit #(
	parameter int READY_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cts_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output cts_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data
);
	import cts_pkg::*;
	`include "cpu_task_scheduler_rr_hpf_srtn_unit_macros.svh"

	localparam int SW = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;
	localparam int CW = $clog2(READY_SLOTS + 1);

	// config
	logic [1:0] mode_q;
	logic [QntW-1:0] quantum_q;

	// table
	logic [READY_SLOTS-1:0] valid_q;
	slot_t slots_q [READY_SLOTS];

	// running task
	logic run_valid_q;
	logic [IdW-1:0] run_id_q;
	logic [RemW-1:0] run_rem_q;
	logic [PriW-1:0] run_pri_q;
	logic [QntW-1:0] qleft_q;
	logic [OrdW-1:0] order_q;

	// item and scan
	state_t state_q, state_d;
	in_item_t item_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] best_q;
	logic best_ok_q;
	logic [SW-1:0] free_q;
	logic free_ok_q;
	logic [2:0] ev1_q, ev2_q;
	logic [IdW-1:0] sub1_q, sub2_q;
	logic two_q;
	logic [1:0] plan_q;
	logic [IdW-1:0] old_id_q;
	logic [RemW-1:0] old_rem_q;
	logic [PriW-1:0] old_pri_q;
	out_item_t out_q;
	logic out_valid_q;

	localparam logic [1:0] PL_NONE = 2'd0;
	localparam logic [1:0] PL_DISP = 2'd1;
	localparam logic [1:0] PL_RRROT = 2'd2;

	logic [SW-1:0] cidx;
	logic [SW-1:0] ins_idx;
	logic cand_better;
	logic [RemW-1:0] rt_eff;
	logic [RemW-1:0] dec_rem;
	logic [QntW-1:0] dec_q;
	logic [QntW-1:0] qeff;

	assign cidx = idx_q[SW-1:0];
	// rotated task goes to the first free slot once the dispatched one is freed
	assign ins_idx = (free_ok_q && free_q < best_q) ? free_q : best_q;
	assign qeff = (quantum_q == '0) ? QntW'(1) : quantum_q;
	assign rt_eff = (item_q.run_time == '0) ? RemW'(1) : item_q.run_time;
	assign dec_rem = (run_rem_q != '0) ? run_rem_q - RemW'(1) : run_rem_q;
	assign dec_q = (qleft_q != '0) ? qleft_q - QntW'(1) : qleft_q;

	function automatic logic [QntW-1:0] qfor(input logic [RemW-1:0] r, input logic [QntW-1:0] q);
		qfor = (r < RemW'(q)) ? r[QntW-1:0] : q;
	endfunction

	cts_compare u_cmp (
		.mode(mode_q),
		.order_now(order_q),
		.cand(slots_q[cidx]),
		.best(slots_q[best_q]),
		.better(cand_better)
	);

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && !in_stall) state_d = ST_SCAN;
			ST_SCAN: if (idx_q == CW'(READY_SLOTS - 1)) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DISPATCH;
			ST_DISPATCH: state_d = ST_REINSERT;
			ST_REINSERT: state_d = ST_EMIT1;
			ST_EMIT1: if (!out_valid_q || !out_stall) state_d = two_q ? ST_EMIT2 : ST_IDLE;
			ST_EMIT2: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RR;
			quantum_q <= QntW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[1:0];
				CFG_QUANTUM: quantum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && free_ok_q && item_q.operation == OP_ARRIVE) begin
			if (mode_q[1] && run_valid_q && rt_eff < run_rem_q)
				slots_q[free_q] <= '{run_id_q, run_rem_q, run_pri_q, 1'b1, order_q};
			else
				slots_q[free_q] <= '{item_q.task_id, rt_eff, item_q.task_priority, 1'b0, order_q};
		end else if (state_q == ST_REINSERT && plan_q == PL_RRROT) begin
			slots_q[ins_idx] <= '{old_id_q, old_rem_q, old_pri_q, 1'b1, order_q};
		end
	end

	// main sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			run_valid_q <= 1'b0;
			run_id_q <= '0;
			run_rem_q <= '0;
			run_pri_q <= '0;
			qleft_q <= '0;
			order_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			best_q <= '0;
			best_ok_q <= 1'b0;
			free_q <= '0;
			free_ok_q <= 1'b0;
			two_q <= 1'b0;
			plan_q <= PL_NONE;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_data;
						idx_q <= '0;
						best_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						best_q <= '0;
						free_q <= '0;
					end
				end
				ST_SCAN: begin
					// one slot per cycle: free search and best search
					if (!valid_q[cidx] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q <= cidx;
					end
					if (valid_q[cidx] && (!best_ok_q || cand_better)) begin
						best_ok_q <= 1'b1;
						best_q <= cidx;
					end
					idx_q <= idx_q + CW'(1);
				end
				ST_DECIDE: begin
					two_q <= 1'b0;
					plan_q <= PL_NONE;
					ev1_q <= EV_NONE;
					sub1_q <= '0;
					if (item_q.operation == OP_ARRIVE) begin
						if (!free_ok_q) begin
							ev1_q <= EV_DROP;
							sub1_q <= item_q.task_id;
						end else if (mode_q[1] && run_valid_q && rt_eff < run_rem_q) begin
							valid_q[free_q] <= 1'b1;
							order_q <= order_q + OrdW'(1);
							ev1_q <= EV_PREEMPT;
							sub1_q <= run_id_q;
							ev2_q <= EV_START;
							sub2_q <= item_q.task_id;
							two_q <= 1'b1;
							run_id_q <= item_q.task_id;
							run_rem_q <= rt_eff;
							run_pri_q <= item_q.task_priority;
							qleft_q <= qfor(rt_eff, qeff);
						end else begin
							valid_q[free_q] <= 1'b1;
							order_q <= order_q + OrdW'(1);
							if (!run_valid_q) begin
								// table was empty, so the new task runs at once
								ev1_q <= EV_START;
								sub1_q <= item_q.task_id;
								run_valid_q <= 1'b1;
								run_id_q <= item_q.task_id;
								run_rem_q <= rt_eff;
								run_pri_q <= item_q.task_priority;
								qleft_q <= qfor(rt_eff, qeff);
								plan_q <= PL_NONE;
								best_q <= free_q;
								best_ok_q <= 1'b1;
							end
						end
					end else if (run_valid_q) begin
						run_rem_q <= dec_rem;
						qleft_q <= dec_q;
						if (dec_rem == '0) begin
							ev1_q <= EV_FINISH;
							sub1_q <= run_id_q;
							run_valid_q <= 1'b0;
							if (best_ok_q) plan_q <= PL_DISP;
						end else if (mode_q == MODE_RR && dec_q == '0) begin
							if (best_ok_q) begin
								ev1_q <= EV_PREEMPT;
								sub1_q <= run_id_q;
								old_id_q <= run_id_q;
								old_rem_q <= dec_rem;
								old_pri_q <= run_pri_q;
								run_valid_q <= 1'b0;
								plan_q <= PL_RRROT;
							end else begin
								qleft_q <= qfor(dec_rem, qeff);
							end
						end
					end
				end
				ST_DISPATCH: begin
					// first result is loaded into the output register with the state it reports;
					// an arrival preempt shows the CPU idle here
					out_q.event_kind <= ev1_q;
					out_q.subject_id <= sub1_q;
					out_q.cpu_busy <= run_valid_q && !two_q;
					out_q.current_id <= (run_valid_q && !two_q) ? run_id_q : '0;
					out_q.current_remaining <= (run_valid_q && !two_q) ? run_rem_q : '0;
					out_q.last_result <= 1'b1;
					if (ev1_q == EV_START && item_q.operation == OP_ARRIVE)
						valid_q[best_q] <= 1'b0;
					if (plan_q == PL_DISP || plan_q == PL_RRROT) begin
						valid_q[best_q] <= 1'b0;
						run_valid_q <= 1'b1;
						run_id_q <= slots_q[best_q].id;
						run_rem_q <= slots_q[best_q].rem;
						run_pri_q <= slots_q[best_q].pri;
						qleft_q <= qfor(slots_q[best_q].rem, qeff);
						ev2_q <= slots_q[best_q].started ? EV_RESUME : EV_START;
						sub2_q <= slots_q[best_q].id;
						two_q <= 1'b1;
						out_q.last_result <= 1'b0;
					end
					if (two_q) out_q.last_result <= 1'b0;
				end
				ST_REINSERT: begin
					// rotated task takes the first free slot as newest entry
					if (plan_q == PL_RRROT) begin
						valid_q[ins_idx] <= 1'b1;
						order_q <= order_q + OrdW'(1);
					end
				end
				ST_EMIT1: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (two_q) begin
							out_q.event_kind <= ev1_q;
						end
					end
				end
				ST_EMIT2: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q.event_kind <= ev2_q;
						out_q.subject_id <= sub2_q;
						out_q.cpu_busy <= 1'b1;
						out_q.current_id <= run_id_q;
						out_q.current_remaining <= run_rem_q;
						out_q.last_result <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`CTS_ASSERT_IMPL(a_busy_fields, clk, arst_n,
		!(out_valid && !out_data.cpu_busy) || (out_data.current_id == '0), "idle CPU shows id")
	`CTS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed")
	`CTS_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall,
		"block took a second item while working")
endmodule

[hw/rtl/cts_compare.sv]
// Shared compare unit: is candidate slot better than the current best.
module cts_compare (
	input logic [1:0] mode,
	input logic [cts_pkg::OrdW-1:0] order_now,
	input cts_pkg::slot_t cand,
	input cts_pkg::slot_t best,
	output logic better
);
	import cts_pkg::*;
	logic [OrdW-1:0] age_c;
	logic [OrdW-1:0] age_b;

	always_comb begin
		age_c = order_now - cand.order;
		age_b = order_now - best.order;
		if (mode == MODE_HPF && cand.pri != best.pri) begin
			better = cand.pri < best.pri;
		end else if (mode[1] && cand.rem != best.rem) begin
			better = cand.rem < best.rem;
		end else begin
			better = age_c > age_b;
		end
	end
endmodule

[tb/tb_checker.sv]
// Checker for the task scheduler: predicts result events from accepted requests and compares.
`timescale 1ns / 1ps
module tb_checker #(
	parameter int READY_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input cts_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_stall,
	input cts_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	output int fail_count,
	output int pending
);
	import cts_pkg::*;

	// scheduler shadow state
	logic slot_used [READY_SLOTS];
	logic [IdW-1:0] slot_tid [READY_SLOTS];
	logic [RemW-1:0] slot_rem [READY_SLOTS];
	logic [PriW-1:0] slot_pri [READY_SLOTS];
	logic slot_begun [READY_SLOTS];
	logic [OrdW-1:0] slot_seq [READY_SLOTS];
	logic [OrdW-1:0] seq_next;
	logic cpu_on;
	logic [IdW-1:0] cpu_tid;
	logic [RemW-1:0] cpu_rem;
	logic [PriW-1:0] cpu_pri;
	logic [QntW-1:0] slice_left;
	logic [1:0] mode_reg;
	logic [7:0] quantum_reg;

	out_item_t expected_events[$];

	function automatic logic [QntW-1:0] slice_for(logic [RemW-1:0] rem);
		logic [RemW-1:0] q;
		q = (quantum_reg == 0) ? 16'd1 : {8'd0, quantum_reg};
		return (rem < q) ? rem[QntW-1:0] : q[QntW-1:0];
	endfunction

	function automatic int first_free();
		for (int i = 0; i < READY_SLOTS; i++)
			if (!slot_used[i]) return i;
		return -1;
	endfunction

	task automatic push_event(logic [2:0] kind, logic [IdW-1:0] subj);
		out_item_t r;
		r.event_kind = kind;
		r.subject_id = subj;
		r.cpu_busy = cpu_on;
		r.current_id = cpu_on ? cpu_tid : '0;
		r.current_remaining = cpu_on ? cpu_rem : '0;
		r.last_result = 1'b0;
		expected_events.push_back(r);
	endtask

	task automatic store_task(int i, logic [IdW-1:0] id, logic [RemW-1:0] rem,
			logic [PriW-1:0] pri, logic st);
		slot_used[i] = 1'b1;
		slot_tid[i] = id;
		slot_rem[i] = rem;
		slot_pri[i] = pri;
		slot_begun[i] = st;
		slot_seq[i] = seq_next;
		seq_next = seq_next + 1'b1;
	endtask

	function automatic bit outranks(int a, int b);
		logic [OrdW-1:0] age_a, age_b;
		age_a = seq_next - slot_seq[a];
		age_b = seq_next - slot_seq[b];
		if (mode_reg == MODE_HPF && slot_pri[a] != slot_pri[b])
			return slot_pri[a] < slot_pri[b];
		if (mode_reg[1] && slot_rem[a] != slot_rem[b])
			return slot_rem[a] < slot_rem[b];
		return age_a > age_b;
	endfunction

	// pick the best waiting task and run it; returns number of events made
	task automatic pick_next(output int made);
		int best;
		best = -1;
		made = 0;
		for (int i = 0; i < READY_SLOTS; i++)
			if (slot_used[i] && (best < 0 || outranks(i, best))) best = i;
		if (best >= 0) begin
			slot_used[best] = 1'b0;
			cpu_on = 1'b1;
			cpu_tid = slot_tid[best];
			cpu_rem = slot_rem[best];
			cpu_pri = slot_pri[best];
			slice_left = slice_for(cpu_rem);
			push_event(slot_begun[best] ? EV_RESUME : EV_START, cpu_tid);
			made = 1;
		end
	endtask

	task automatic predict_request(in_item_t req);
		int n, m, f;
		logic [RemW-1:0] rt, orem;
		logic [IdW-1:0] oid;
		logic [PriW-1:0] opri;
		bit any;
		n = 0;
		if (req.operation == OP_ARRIVE) begin
			rt = (req.run_time == 0) ? 16'd1 : req.run_time;
			f = first_free();
			if (f < 0) begin
				push_event(EV_DROP, req.task_id);
				n++;
			end else if (mode_reg[1] && cpu_on && rt < cpu_rem) begin
				oid = cpu_tid;
				store_task(f, cpu_tid, cpu_rem, cpu_pri, 1'b1);
				cpu_on = 1'b0;
				push_event(EV_PREEMPT, oid);
				cpu_on = 1'b1;
				cpu_tid = req.task_id;
				cpu_rem = rt;
				cpu_pri = req.task_priority;
				slice_left = slice_for(rt);
				push_event(EV_START, req.task_id);
				n += 2;
			end else begin
				store_task(f, req.task_id, rt, req.task_priority, 1'b0);
				if (!cpu_on) begin
					pick_next(m);
					n += m;
				end
				if (n == 0) begin
					push_event(EV_NONE, '0);
					n++;
				end
			end
		end else if (!cpu_on) begin
			pick_next(m);
			n += m;
			if (n == 0) begin
				push_event(EV_NONE, '0);
				n++;
			end
		end else begin
			if (cpu_rem != 0) cpu_rem--;
			if (slice_left != 0) slice_left--;
			if (cpu_rem == 0) begin
				cpu_on = 1'b0;
				push_event(EV_FINISH, cpu_tid);
				n++;
				pick_next(m);
			end else if (mode_reg == MODE_RR && slice_left == 0) begin
				any = 0;
				for (int i = 0; i < READY_SLOTS; i++) if (slot_used[i]) any = 1;
				if (any) begin
					oid = cpu_tid;
					opri = cpu_pri;
					orem = cpu_rem;
					cpu_on = 1'b0;
					push_event(EV_PREEMPT, oid);
					pick_next(m);
					f = first_free();
					if (f >= 0) store_task(f, oid, orem, opri, 1'b1);
				end else begin
					slice_left = slice_for(cpu_rem);
					push_event(EV_NONE, '0);
				end
			end else begin
				push_event(EV_NONE, '0);
			end
		end
		expected_events[$].last_result = 1'b1;
	endtask

	// watch the channels
	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < READY_SLOTS; i++) slot_used[i] = 1'b0;
			seq_next = '0;
			cpu_on = 1'b0;
			cpu_tid = '0;
			cpu_rem = '0;
			cpu_pri = '0;
			slice_left = '0;
			mode_reg = MODE_RR;
			quantum_reg = 8'd1;
			fail_count = 0;
			expected_events.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: %p", out_data);
					fail_count++;
				end else begin
					e = expected_events.pop_front();
					if (out_data.event_kind !== e.event_kind) begin
						$error("event_kind exp %0d got %0d", e.event_kind, out_data.event_kind);
						fail_count++;
					end
					if (out_data.subject_id !== e.subject_id) begin
						$error("subject_id exp %0d got %0d", e.subject_id, out_data.subject_id);
						fail_count++;
					end
					if (out_data.cpu_busy !== e.cpu_busy) begin
						$error("cpu_busy exp %0d got %0d", e.cpu_busy, out_data.cpu_busy);
						fail_count++;
					end
					if (out_data.current_id !== e.current_id) begin
						$error("current_id exp %0d got %0d", e.current_id, out_data.current_id);
						fail_count++;
					end
					if (out_data.current_remaining !== e.current_remaining) begin
						$error("current_remaining exp %0d got %0d", e.current_remaining,
							out_data.current_remaining);
						fail_count++;
					end
					if (out_data.last_result !== e.last_result) begin
						$error("last_result exp %0d got %0d", e.last_result, out_data.last_result);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_MODE) mode_reg = cfg_data[1:0];
				else quantum_reg = cfg_data;
			end
			if (in_valid && !in_stall) predict_request(in_data);
			pending = expected_events.size();
		end
	end
endmodule

[tb/tb_top.sv]
// Top of the task scheduler testbench: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_top;
	import cts_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_MODE;
	logic [7:0] cfg_data = '0;
	int fail_count;
	int pending;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit stall_mode = 1'b0;
	bit done = 1'b0;
	logic [7:0] id_seq = '0;

	always #5 clk = ~clk;

	cpu_task_scheduler_rr_hpf_srtn_unit u_top (.*);

	tb_checker u_chk (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else if (stall_mode) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one request and wait for acceptance
	task automatic send(logic op, logic [7:0] id, logic [15:0] rt, logic [7:0] pri);
		in_item_t r;
		r.operation = op;
		r.task_id = id;
		r.run_time = rt;
		r.task_priority = pri;
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// random request: mostly ticks with small run times so tasks finish
	task automatic random_req();
		logic [15:0] rt;
		logic [7:0] pri;
		case ($urandom_range(0, 9))
			0: rt = 16'($urandom);
			1: rt = 16'd0;
			2: rt = 16'hffff;
			default: rt = 16'($urandom_range(1, 12));
		endcase
		pri = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		if ($urandom_range(0, 9) < 4) begin
			send(OP_ARRIVE, ($urandom_range(0, 7) == 0) ? 8'($urandom) : id_seq, rt, pri);
			id_seq = id_seq + 1'b1;
		end else begin
			send(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		logic [7:0] qlist [6];
		logic [1:0] mlist [6];
		int burst;
		qlist = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'd5};
		mlist = '{MODE_RR, MODE_HPF, MODE_SRTN, MODE_SPARE, MODE_RR, MODE_SRTN};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, special cases, round-robin and SRTN modes
		write_reg(CFG_QUANTUM, 8'd2);
		send(OP_TICK, 8'd0, 16'd0, 8'd0);
		send(OP_ARRIVE, 8'hff, 16'd0, 8'hff);
		send(OP_ARRIVE, 8'h00, 16'hffff, 8'h00);
		send(OP_ARRIVE, 8'h55, 16'd3, 8'haa);
		repeat (4) send(OP_TICK, 8'haa, 16'h5555, 8'h55);
		drain();
		write_reg(CFG_MODE, 8'(MODE_SRTN));
		send(OP_ARRIVE, 8'd10, 16'd50, 8'd1);
		send(OP_ARRIVE, 8'd11, 16'd5, 8'd2);
		send(OP_ARRIVE, 8'd12, 16'd60, 8'd0);
		send(OP_TICK, 8'd0, 16'd0, 8'd0);
		// fill the table to force drops
		for (int i = 0; i < 18; i++) send(OP_ARRIVE, 8'(20 + i), 16'd100, 8'd0);
		// let the results drain, then switch to priority mode
		drain();
		write_reg(CFG_MODE, 8'(MODE_HPF));

		// random phases with config changes between them
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_MODE, 8'(mlist[ph]));
			write_reg(CFG_QUANTUM, qlist[ph]);
			stall_mode = ph[0];
			for (int k = 0; k < 115; k++) begin
				if (ph == 2 && k == 20) begin
					// long receiver hold-off while requests keep coming
					fork
						begin
							hold_off = 1'b1;
							repeat (200) @(posedge clk);
							hold_off = 1'b0;
						end
					join_none
				end
				random_req();
				burst = $urandom_range(0, 4);
				if (burst == 0) gap();
			end
			drain();
		end

		if (fail_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
